// ----- hw/rtl/otat_pkg.sv -----
`default_nettype none
package otat_pkg;

  localparam int MAX_OBJECTS_DEF = 64;

  localparam int CLASS_W    = 4;
  localparam int POS_W      = 16;
  localparam int ORIENT_W   = 64;
  localparam int BOX_W      = 48;
  localparam int ID_W       = 7;
  localparam int IDX_OUT_W  = 6;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam int MASK_W     = 16;

  localparam logic [CFG_DATA_W-1:0] MERGE_DIST_RST = CFG_DATA_W'(40000);
  localparam logic [MASK_W-1:0]     LIMITED_RST    = MASK_W'(14);

  typedef enum logic [STATUS_W-1:0] {
    STAT_MERGED       = 3'd0,
    STAT_ADDED        = 3'd1,
    STAT_POSE_UPDATED = 3'd2,
    STAT_NOT_FOUND    = 3'd3,
    STAT_TABLE_FULL   = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MERGE_DIST   = 1'b0,
    REG_LIMITED_MASK = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_DETECT = 1'b0,
    CMD_POSE   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic cls_we;
    logic xy_we;
    logic pos_we;
    logic orient_we;
    logic box_we;
  } wr_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/otat_scan_mem.sv -----
`default_nettype none
module otat_scan_mem #(
  parameter int MAX_OBJECTS = otat_pkg::MAX_OBJECTS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rd_en,
  input  wire [$clog2(MAX_OBJECTS)-1:0]       rd_addr,
  output logic [otat_pkg::CLASS_W-1:0]        rd_cls_r,
  output logic [otat_pkg::POS_W-1:0]          rd_x_r,
  output logic [otat_pkg::POS_W-1:0]          rd_y_r,
  input  otat_pkg::wr_ctl_t                   wr_ctl,
  input  wire [$clog2(MAX_OBJECTS)-1:0]       wr_addr,
  input  wire [otat_pkg::CLASS_W-1:0]         wr_cls,
  input  wire [otat_pkg::POS_W-1:0]           wr_x,
  input  wire [otat_pkg::POS_W-1:0]           wr_y
);

  localparam int PW = otat_pkg::POS_W;

  logic [otat_pkg::CLASS_W-1:0] cls_mem_r [MAX_OBJECTS];
  logic [2*PW-1:0]              xy_mem_r  [MAX_OBJECTS];

  always_ff @(posedge clk) begin
    if (wr_ctl.cls_we) begin
      cls_mem_r[wr_addr] <= wr_cls;
    end
    if (wr_ctl.xy_we) begin
      xy_mem_r[wr_addr] <= {wr_y, wr_x};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_cls_r <= cls_mem_r[rd_addr];
      rd_x_r   <= xy_mem_r[rd_addr][PW-1:0];
      rd_y_r   <= xy_mem_r[rd_addr][2*PW-1:PW];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/otat_attr_mem.sv -----
`default_nettype none
module otat_attr_mem #(
  parameter int MAX_OBJECTS = otat_pkg::MAX_OBJECTS_DEF
) (
  input  wire                                 clk,
  input  otat_pkg::wr_ctl_t                   wr_ctl,
  input  wire [$clog2(MAX_OBJECTS)-1:0]       wr_addr,
  input  wire [3*otat_pkg::POS_W-1:0]         wr_pos,
  input  wire [otat_pkg::ORIENT_W-1:0]        wr_orient,
  input  wire [otat_pkg::BOX_W-1:0]           wr_box
);

  // full pose and box per entry; xy copy for the scan lives in the scan memory
  logic [3*otat_pkg::POS_W-1:0]  pos_mem_r    [MAX_OBJECTS];
  logic [otat_pkg::ORIENT_W-1:0] orient_mem_r [MAX_OBJECTS];
  logic [otat_pkg::BOX_W-1:0]    box_mem_r    [MAX_OBJECTS];

  always_ff @(posedge clk) begin
    if (wr_ctl.pos_we) begin
      pos_mem_r[wr_addr] <= wr_pos;
    end
    if (wr_ctl.orient_we) begin
      orient_mem_r[wr_addr] <= wr_orient;
    end
    if (wr_ctl.box_we) begin
      box_mem_r[wr_addr] <= wr_box;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/otat_ctrl.sv -----
`default_nettype none
module otat_ctrl #(
  parameter int MAX_OBJECTS = otat_pkg::MAX_OBJECTS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 in_cmd,
  input  wire [otat_pkg::ID_W-1:0]            in_track_id,
  input  wire [otat_pkg::CLASS_W-1:0]         in_class_code,
  input  wire                                 in_has_class,
  input  wire [otat_pkg::POS_W-1:0]           in_pos_x,
  input  wire [otat_pkg::POS_W-1:0]           in_pos_y,
  input  wire [otat_pkg::POS_W-1:0]           in_pos_z,
  input  wire [otat_pkg::ORIENT_W-1:0]        in_orientation_packed,
  input  wire [otat_pkg::BOX_W-1:0]           in_box_size_packed,
  input  wire [otat_pkg::CFG_DATA_W-1:0]      merge_dist_sq,
  input  wire [otat_pkg::MASK_W-1:0]          limited_class_mask,
  output logic                                rd_en,
  output logic [$clog2(MAX_OBJECTS)-1:0]      rd_addr,
  input  wire [otat_pkg::CLASS_W-1:0]         rd_cls,
  input  wire [otat_pkg::POS_W-1:0]           rd_x,
  input  wire [otat_pkg::POS_W-1:0]           rd_y,
  output otat_pkg::wr_ctl_t                   wr_ctl,
  output logic [$clog2(MAX_OBJECTS)-1:0]      wr_addr,
  output logic [otat_pkg::CLASS_W-1:0]        wr_cls,
  output logic [3*otat_pkg::POS_W-1:0]        wr_pos,
  output logic [otat_pkg::ORIENT_W-1:0]       wr_orient,
  output logic [otat_pkg::BOX_W-1:0]          wr_box,
  output logic                                res_valid,
  output otat_pkg::status_t                   res_status,
  output logic [otat_pkg::IDX_OUT_W-1:0]      res_idx,
  input  wire                                 res_take
);

  localparam int AW     = $clog2(MAX_OBJECTS);
  localparam int CW     = $clog2(MAX_OBJECTS + 1);
  localparam int PW     = otat_pkg::POS_W;
  localparam int IW     = otat_pkg::ID_W;
  localparam int OW     = otat_pkg::IDX_OUT_W;
  localparam int SQW    = 2 * PW;
  localparam int CMPW   = SQW + 1;
  localparam int IDCW   = CW + IW;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_OBJECTS);

  otat_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     scan_idx_r;

  logic                         item_cmd_r;
  logic [IW-1:0]                item_id_r;
  logic [otat_pkg::CLASS_W-1:0] item_cls_r;
  logic                         item_has_class_r;
  logic [PW-1:0]                item_x_r, item_y_r, item_z_r;
  logic [otat_pkg::ORIENT_W-1:0] item_orient_r;
  logic [otat_pkg::BOX_W-1:0]   item_box_r;

  logic          p1_v_r, p2_v_r;
  logic [AW-1:0] p1_idx_r, p2_idx_r;
  logic          p2_cls_match_r;
  logic [SQW-1:0] sqx_r, sqy_r;

  logic          class_found_r, gate_found_r;
  logic [AW-1:0] class_idx_r, gate_idx_r;

  otat_pkg::status_t res_status_r, res_status_nxt;
  logic [AW-1:0]     res_idx_r, res_idx_nxt;

  logic                  accept, scan_issue, scan_done, gate_hit, id_ok, limited;
  logic signed [PW:0]    dx, dy;
  logic signed [2*PW+1:0] sqx_full, sqy_full;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != otat_pkg::S_IDLE);
  assign scan_issue = (state_r == otat_pkg::S_SCAN) && (scan_idx_r < count_r);
  assign scan_done  = (state_r == otat_pkg::S_SCAN) && !scan_issue && !p1_v_r && !p2_v_r;
  assign rd_en      = scan_issue;
  assign rd_addr    = scan_idx_r[AW-1:0];

  assign dx       = $signed({rd_x[PW-1], rd_x}) - $signed({item_x_r[PW-1], item_x_r});
  assign dy       = $signed({rd_y[PW-1], rd_y}) - $signed({item_y_r[PW-1], item_y_r});
  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;
  assign gate_hit = (CMPW'(sqx_r) + CMPW'(sqy_r)) < CMPW'(merge_dist_sq);

  assign id_ok   = !item_id_r[IW-1] && (IDCW'(item_id_r[IW-2:0]) < IDCW'(count_r));
  assign limited = limited_class_mask[item_cls_r];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      otat_pkg::S_IDLE:   if (accept) state_nxt = otat_pkg::S_SCAN;
      otat_pkg::S_SCAN:   if (scan_done) state_nxt = otat_pkg::S_DECIDE;
      otat_pkg::S_DECIDE: state_nxt = otat_pkg::S_DONE;
      otat_pkg::S_DONE:   if (res_take) state_nxt = otat_pkg::S_IDLE;
      default:            state_nxt = otat_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    wr_ctl         = '0;
    wr_addr        = '0;
    count_nxt      = count_r;
    res_status_nxt = otat_pkg::STAT_NOT_FOUND;
    res_idx_nxt    = '0;
    if (state_r == otat_pkg::S_DECIDE) begin
      if (item_cmd_r == otat_pkg::CMD_DETECT) begin
        if (gate_found_r || (limited && class_found_r)) begin
          wr_addr        = gate_found_r ? gate_idx_r : class_idx_r;
          wr_ctl         = '{cls_we: 1'b1, xy_we: 1'b1, pos_we: 1'b1,
                             orient_we: 1'b1, box_we: 1'b1};
          res_status_nxt = otat_pkg::STAT_MERGED;
          res_idx_nxt    = wr_addr;
        end else if (count_r < MAX_CNT) begin
          wr_addr        = count_r[AW-1:0];
          wr_ctl         = '{cls_we: 1'b1, xy_we: 1'b1, pos_we: 1'b1,
                             orient_we: 1'b1, box_we: 1'b1};
          count_nxt      = count_r + 1'b1;
          res_status_nxt = otat_pkg::STAT_ADDED;
          res_idx_nxt    = wr_addr;
        end else begin
          res_status_nxt = otat_pkg::STAT_TABLE_FULL;
        end
      end else begin
        if (id_ok || (item_has_class_r && class_found_r)) begin
          wr_addr        = id_ok ? AW'(item_id_r[IW-2:0]) : class_idx_r;
          wr_ctl         = '{cls_we: 1'b0, xy_we: 1'b1, pos_we: 1'b1,
                             orient_we: 1'b1, box_we: 1'b0};
          res_status_nxt = otat_pkg::STAT_POSE_UPDATED;
          res_idx_nxt    = wr_addr;
        end
      end
    end
  end

  assign wr_cls     = item_cls_r;
  assign wr_pos     = {item_z_r, item_y_r, item_x_r};
  assign wr_orient  = item_orient_r;
  assign wr_box     = item_box_r;
  assign res_valid  = (state_r == otat_pkg::S_DONE);
  assign res_status = res_status_r;
  assign res_idx    = OW'(res_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= otat_pkg::S_IDLE;
      count_r       <= '0;
      scan_idx_r    <= '0;
      p1_v_r        <= 1'b0;
      p2_v_r        <= 1'b0;
      class_found_r <= 1'b0;
      gate_found_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      p1_v_r  <= scan_issue;
      p2_v_r  <= p1_v_r;
      if (accept) begin
        scan_idx_r    <= '0;
        class_found_r <= 1'b0;
        gate_found_r  <= 1'b0;
      end else begin
        if (scan_issue) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
        if (p2_v_r && p2_cls_match_r && !class_found_r) begin
          class_found_r <= 1'b1;
        end
        if (p2_v_r && p2_cls_match_r && gate_hit && !gate_found_r) begin
          gate_found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd_r       <= in_cmd;
      item_id_r        <= in_track_id;
      item_cls_r       <= in_class_code;
      item_has_class_r <= in_has_class;
      item_x_r         <= in_pos_x;
      item_y_r         <= in_pos_y;
      item_z_r         <= in_pos_z;
      item_orient_r    <= in_orientation_packed;
      item_box_r       <= in_box_size_packed;
    end
    p1_idx_r       <= rd_addr;
    p2_idx_r       <= p1_idx_r;
    p2_cls_match_r <= (rd_cls == item_cls_r);
    sqx_r          <= sqx_full[SQW-1:0];
    sqy_r          <= sqy_full[SQW-1:0];
    if (p2_v_r && p2_cls_match_r && !class_found_r) begin
      class_idx_r <= p2_idx_r;
    end
    if (p2_v_r && p2_cls_match_r && gate_hit && !gate_found_r) begin
      gate_idx_r <= p2_idx_r;
    end
    if (state_r == otat_pkg::S_DECIDE) begin
      res_status_r <= res_status_nxt;
      res_idx_r    <= res_idx_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("entry count above table size");

  a_add_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == otat_pkg::S_DECIDE && res_status_nxt == otat_pkg::STAT_ADDED)
    |=> (count_r == CW'($past(count_r) + 1'b1)))
    else $error("add did not bump entry count");

  a_count_only_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> ($past(state_r) == otat_pkg::S_DECIDE))
    else $error("entry count changed outside decide");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == otat_pkg::S_IDLE) |-> (!p1_v_r && !p2_v_r))
    else $error("scan pipe busy while idle");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ctl.xy_we |-> (CW'(wr_addr) <= count_r))
    else $error("write beyond filled entries");

endmodule
`default_nettype wire

// ----- hw/rtl/object_track_association_table_top.sv -----
// Object track table with gated first-match association.
// Input channel (in_valid/in_stall): one word per detection (cmd 0) or pose
// update (cmd 1). in_stall is high from acceptance until the result word has
// moved into the output register, so one word is in work at a time.
// Output channel (out_valid/out_stall): one word per input, status and
// entry index. The output register holds a word while out_stall is high;
// the next input is taken meanwhile and its result waits in the core.
// Config port: cfg_we with cfg_index 0 writes the squared merge gate,
// index 1 the limited-class mask; write only while idle.
// Flow: each word scans every filled entry through the class/xy memory,
// one read per cycle, then a two-stage square/compare pipe, a decide and
// write-back state and a hand-off state. The scan memory has a single
// read port, so the filled entries are read one after another.
// Reset (rst_n low, synchronous) empties the table and loads gate 40000
// and mask 14; entry memories are not cleared, only unfilled.
`default_nettype none
module object_track_association_table_top #(
  parameter int MAX_OBJECTS = otat_pkg::MAX_OBJECTS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_cmd,
  input  wire [otat_pkg::ID_W-1:0]         in_track_id,
  input  wire [otat_pkg::CLASS_W-1:0]      in_class_code,
  input  wire                              in_has_class,
  input  wire [otat_pkg::POS_W-1:0]        in_pos_x,
  input  wire [otat_pkg::POS_W-1:0]        in_pos_y,
  input  wire [otat_pkg::POS_W-1:0]        in_pos_z,
  input  wire [otat_pkg::ORIENT_W-1:0]     in_orientation_packed,
  input  wire [otat_pkg::BOX_W-1:0]        in_box_size_packed,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [otat_pkg::STATUS_W-1:0]    out_status,
  output logic [otat_pkg::IDX_OUT_W-1:0]   out_entry_index,
  input  wire                              cfg_we,
  input  wire [otat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [otat_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(MAX_OBJECTS);
  localparam int PW = otat_pkg::POS_W;

  logic [otat_pkg::CFG_DATA_W-1:0] merge_dist_r;
  logic [otat_pkg::MASK_W-1:0]     limited_mask_r;

  logic                            out_valid_r;
  logic [otat_pkg::STATUS_W-1:0]   out_status_r;
  logic [otat_pkg::IDX_OUT_W-1:0]  out_idx_r;

  logic                            rd_en;
  logic [AW-1:0]                   rd_addr;
  logic [otat_pkg::CLASS_W-1:0]    rd_cls;
  logic [PW-1:0]                   rd_x, rd_y;
  otat_pkg::wr_ctl_t               wr_ctl;
  logic [AW-1:0]                   wr_addr;
  logic [otat_pkg::CLASS_W-1:0]    wr_cls;
  logic [3*PW-1:0]                 wr_pos;
  logic [otat_pkg::ORIENT_W-1:0]   wr_orient;
  logic [otat_pkg::BOX_W-1:0]      wr_box;
  logic                            res_valid, res_take;
  otat_pkg::status_t               res_status;
  logic [otat_pkg::IDX_OUT_W-1:0]  res_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merge_dist_r   <= otat_pkg::MERGE_DIST_RST;
      limited_mask_r <= otat_pkg::LIMITED_RST;
    end else if (cfg_we) begin
      case (otat_pkg::cfg_reg_t'(cfg_index))
        otat_pkg::REG_MERGE_DIST:   merge_dist_r   <= cfg_wdata;
        otat_pkg::REG_LIMITED_MASK: limited_mask_r <= cfg_wdata[otat_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_status_r <= res_status;
      out_idx_r    <= res_idx;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_idx_r;

  otat_ctrl #(.MAX_OBJECTS(MAX_OBJECTS)) u_ctrl (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_cmd                (in_cmd),
    .in_track_id           (in_track_id),
    .in_class_code         (in_class_code),
    .in_has_class          (in_has_class),
    .in_pos_x              (in_pos_x),
    .in_pos_y              (in_pos_y),
    .in_pos_z              (in_pos_z),
    .in_orientation_packed (in_orientation_packed),
    .in_box_size_packed    (in_box_size_packed),
    .merge_dist_sq         (merge_dist_r),
    .limited_class_mask    (limited_mask_r),
    .rd_en                 (rd_en),
    .rd_addr               (rd_addr),
    .rd_cls                (rd_cls),
    .rd_x                  (rd_x),
    .rd_y                  (rd_y),
    .wr_ctl                (wr_ctl),
    .wr_addr               (wr_addr),
    .wr_cls                (wr_cls),
    .wr_pos                (wr_pos),
    .wr_orient             (wr_orient),
    .wr_box                (wr_box),
    .res_valid             (res_valid),
    .res_status            (res_status),
    .res_idx               (res_idx),
    .res_take              (res_take)
  );

  otat_scan_mem #(.MAX_OBJECTS(MAX_OBJECTS)) u_scan_mem (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_cls_r (rd_cls),
    .rd_x_r   (rd_x),
    .rd_y_r   (rd_y),
    .wr_ctl   (wr_ctl),
    .wr_addr  (wr_addr),
    .wr_cls   (wr_cls),
    .wr_x     (wr_pos[PW-1:0]),
    .wr_y     (wr_pos[2*PW-1:PW])
  );

  otat_attr_mem #(.MAX_OBJECTS(MAX_OBJECTS)) u_attr_mem (
    .clk       (clk),
    .wr_ctl    (wr_ctl),
    .wr_addr   (wr_addr),
    .wr_pos    (wr_pos),
    .wr_orient (wr_orient),
    .wr_box    (wr_box)
  );

endmodule
`default_nettype wire

// ----- tb/sv/object_track_association_table_top_tb.sv -----
`timescale 1ns / 1ps
module object_track_association_table_top_tb;

  localparam int TABLE_DEPTH = otat_pkg::MAX_OBJECTS_DEF;
  localparam int ID_W        = otat_pkg::ID_W;
  localparam int CLASS_W     = otat_pkg::CLASS_W;
  localparam int POS_W       = otat_pkg::POS_W;
  localparam int ORIENT_W    = otat_pkg::ORIENT_W;
  localparam int BOX_W       = otat_pkg::BOX_W;
  localparam int IDX_OUT_W   = otat_pkg::IDX_OUT_W;
  localparam int STATUS_W    = otat_pkg::STATUS_W;
  localparam int CFG_IDX_W   = otat_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = otat_pkg::CFG_DATA_W;
  localparam int MASK_W      = otat_pkg::MASK_W;

  typedef struct packed {
    otat_pkg::cmd_t          cmd;
    logic signed [ID_W-1:0]  track_id;
    logic [CLASS_W-1:0]      class_code;
    logic                    has_class;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [ORIENT_W-1:0]     orient;
    logic [BOX_W-1:0]        box;
  } track_word_t;

  typedef struct packed {
    otat_pkg::status_t    status;
    logic [IDX_OUT_W-1:0] index;
  } assoc_result_t;

  typedef struct packed {
    track_word_t   word;
    logic          typed;
    assoc_result_t want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  wire                   in_stall;
  track_word_t           in_word = '0;
  wire                   out_valid;
  logic                  out_stall = 1'b0;
  wire [STATUS_W-1:0]    out_status;
  wire [IDX_OUT_W-1:0]   out_entry_index;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow of the track table
  logic [CLASS_W-1:0]      trk_class [TABLE_DEPTH];
  logic signed [POS_W-1:0] trk_x [TABLE_DEPTH];
  logic signed [POS_W-1:0] trk_y [TABLE_DEPTH];
  int                      n_tracks = 0;
  logic [CFG_DATA_W-1:0]   gate_sq = otat_pkg::MERGE_DIST_RST;
  logic [MASK_W-1:0]       limited_mask = otat_pkg::LIMITED_RST;

  assoc_result_t outcome_q[$];
  int            mismatches = 0;
  int            checked = 0;
  int            words_sent = 0;
  int            settings_used = 0;
  int            status_seen [8] = '{default: 0};
  logic          calm_stretch = 1'b0;

  object_track_association_table_top uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_cmd                (in_word.cmd),
    .in_track_id           (in_word.track_id),
    .in_class_code         (in_word.class_code),
    .in_has_class          (in_word.has_class),
    .in_pos_x              (in_word.pos_x),
    .in_pos_y              (in_word.pos_y),
    .in_pos_z              (in_word.pos_z),
    .in_orientation_packed (in_word.orient),
    .in_box_size_packed    (in_word.box),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_entry_index       (out_entry_index),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** object_track_association_table_top: FAILED **");
    $finish;
  end

  function automatic int first_of_class(logic [CLASS_W-1:0] cls);
    int i;
    for (i = 0; i < n_tracks; i++) begin
      if (trk_class[i] == cls) return i;
    end
    return -1;
  endfunction

  // gated association: updates the shadow table, returns the outcome
  function automatic assoc_result_t track_table_update(track_word_t w);
    int            hit;
    int            i;
    longint        dx;
    longint        dy;
    assoc_result_t r;
    hit = -1;
    r.index = '0;
    if (w.cmd == otat_pkg::CMD_DETECT) begin
      for (i = 0; i < n_tracks && hit < 0; i++) begin
        if (trk_class[i] == w.class_code) begin
          dx = longint'(trk_x[i]) - longint'(w.pos_x);
          dy = longint'(trk_y[i]) - longint'(w.pos_y);
          if (dx * dx + dy * dy < longint'(gate_sq)) hit = i;
        end
      end
      if (hit < 0 && limited_mask[w.class_code]) hit = first_of_class(w.class_code);
      if (hit >= 0) begin
        r.status = otat_pkg::STAT_MERGED;
      end else if (n_tracks < TABLE_DEPTH) begin
        hit = n_tracks;
        n_tracks++;
        r.status = otat_pkg::STAT_ADDED;
      end else begin
        r.status = otat_pkg::STAT_TABLE_FULL;
      end
      if (hit >= 0) trk_class[hit] = w.class_code;
    end else begin
      if (!w.track_id[ID_W-1] && int'(w.track_id) < n_tracks) hit = int'(w.track_id);
      if (hit < 0 && w.has_class) hit = first_of_class(w.class_code);
      r.status = (hit >= 0) ? otat_pkg::STAT_POSE_UPDATED : otat_pkg::STAT_NOT_FOUND;
    end
    if (hit >= 0) begin
      trk_x[hit] = w.pos_x;
      trk_y[hit] = w.pos_y;
      r.index = hit[IDX_OUT_W-1:0];
    end
    return r;
  endfunction

  // mostly detections near live tracks and pose updates on live ids, some noise
  function automatic track_word_t random_word(int spread);
    track_word_t w;
    logic [63:0] bits;
    int          pick;
    int          k;
    bits = {$urandom, $urandom};
    w.orient = {$urandom, $urandom};
    w.box = bits[BOX_W-1:0];
    w.pos_z = bits[63:48];
    w.track_id = ID_W'($urandom_range(0, 64) - 1);
    w.has_class = 1'($urandom_range(0, 1));
    w.class_code = CLASS_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(0, 3));
    w.pos_x = POS_W'($urandom);
    w.pos_y = POS_W'($urandom);
    w.cmd = otat_pkg::CMD_DETECT;
    pick = $urandom_range(0, 99);
    if (pick < 55 && n_tracks > 0) begin
      k = $urandom_range(0, n_tracks - 1);
      w.class_code = trk_class[k];
      w.pos_x = POS_W'(int'(trk_x[k]) + int'($urandom_range(0, 2 * spread)) - spread);
      w.pos_y = POS_W'(int'(trk_y[k]) + int'($urandom_range(0, 2 * spread)) - spread);
    end else if (pick < 70) begin
      if ($urandom_range(0, 1) == 1) begin
        w.pos_x = POS_W'(int'($urandom_range(0, 8 * spread)) - 4 * spread);
        w.pos_y = POS_W'(int'($urandom_range(0, 8 * spread)) - 4 * spread);
      end
    end else if (pick < 88) begin
      w.cmd = otat_pkg::CMD_POSE;
      if (n_tracks > 0 && $urandom_range(0, 2) != 0)
        w.track_id = ID_W'($urandom_range(0, n_tracks - 1));
    end else begin
      w.cmd = otat_pkg::cmd_t'($urandom_range(0, 1));
      w.class_code = CLASS_W'($urandom_range(0, 15));
    end
    return w;
  endfunction

  task automatic send_word(track_word_t w, logic typed, assoc_result_t want);
    assoc_result_t got;
    while (!calm_stretch && $urandom_range(0, 99) < 36) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = track_table_update(w);
    outcome_q.insert(outcome_q.size(), typed ? want : got);
    words_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic program_gate(logic [CFG_DATA_W-1:0] gate, logic [CFG_DATA_W-1:0] mask_word);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= otat_pkg::REG_MERGE_DIST;
    cfg_wdata <= gate;
    @(negedge clk);
    cfg_index <= otat_pkg::REG_LIMITED_MASK;
    cfg_wdata <= mask_word;
    @(negedge clk);
    cfg_we <= 1'b0;
    gate_sq = gate;
    limited_mask = mask_word[MASK_W-1:0];
    settings_used++;
  endtask

  always @(negedge clk) begin
    out_stall <= !calm_stretch && ($urandom_range(0, 99) < 36);
  end

  always @(posedge clk) begin : check_results
    assoc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result word: status %0d index %0d", $time,
                   out_status, out_entry_index);
      end else begin
        want = outcome_q.pop_front();
        checked++;
        status_seen[want.status]++;
        if (out_status !== want.status || out_entry_index !== want.index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: got status %0d index %0d, wanted status %0d index %0d", $time,
                     out_status, out_entry_index, want.status, want.index);
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t             plan[$];
    int                    p;
    int                    j;
    int                    n;
    int                    spread;
    logic [CFG_DATA_W-1:0] gate;
    logic [CFG_DATA_W-1:0] mask_word;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // empty table, reset gate and mask
    plan.insert(plan.size(), '{'{otat_pkg::CMD_POSE, 0, 0, 0, 0, 0, 0, 64'h0, 48'h0}, 1,
                               '{otat_pkg::STAT_NOT_FOUND, 0}});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_POSE, -1, 1, 1, 0, 0, 0, 64'h0, 48'h0}, 1,
                               '{otat_pkg::STAT_NOT_FOUND, 0}});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_DETECT, 0, 0, 0, 0, 0, 0, 64'h0, 48'h0}, 1,
                               '{otat_pkg::STAT_ADDED, 0}});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_DETECT, 0, 0, 0, 199, 0, 5,
                                 64'h1234_5678_9ABC_DEF0, 48'h0001_0002_0003}, 1,
                               '{otat_pkg::STAT_MERGED, 0}});
    // exactly on the gate does not merge
    plan.insert(plan.size(), '{'{otat_pkg::CMD_DETECT, 0, 0, 0, 399, 0, 0, 64'h0, 48'h0}, 1,
                               '{otat_pkg::STAT_ADDED, 1}});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_DETECT, 63, 1, 1, 32767, 32767, 32767,
                                 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF}, 1,
                               '{otat_pkg::STAT_ADDED, 2}});
    // limited class merges however far away
    plan.insert(plan.size(), '{'{otat_pkg::CMD_DETECT, 0, 1, 0, -32768, -32768, -32768,
                                 64'h8000_8000_8000_8000, 48'h8000_8000_8000}, 1,
                               '{otat_pkg::STAT_MERGED, 2}});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_DETECT, 0, 2, 0, -32768, 32767, 0,
                                 64'h7FFF_7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF}, 1,
                               '{otat_pkg::STAT_ADDED, 3}});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_DETECT, 0, 3, 0, 100, -100, 0, 64'h0, 48'h0},
                               1, '{otat_pkg::STAT_ADDED, 4}});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_DETECT, 0, 15, 1, 0, 0, 0, 64'h0, 48'h0}, 1,
                               '{otat_pkg::STAT_ADDED, 5}});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_DETECT, 0, 15, 0, 0, 0, 0, 64'h0, 48'h0}, 1,
                               '{otat_pkg::STAT_MERGED, 5}});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_POSE, 4, 0, 0, 7, 7, 7,
                                 64'hFFFF_FFFF_FFFF_FFFF, 48'h0}, 1,
                               '{otat_pkg::STAT_POSE_UPDATED, 4}});
    // id past the fill level, no class fallback
    plan.insert(plan.size(), '{'{otat_pkg::CMD_POSE, 63, 0, 0, 0, 0, 0, 64'h0, 48'h0}, 1,
                               '{otat_pkg::STAT_NOT_FOUND, 0}});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_POSE, 63, 2, 1, 0, 0, 0, 64'h0, 48'h0}, 1,
                               '{otat_pkg::STAT_POSE_UPDATED, 3}});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_POSE, -1, 0, 1, 500, 500, 0, 64'h0, 48'h0},
                               1, '{otat_pkg::STAT_POSE_UPDATED, 0}});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_POSE, -1, 7, 1, 0, 0, 0, 64'h0, 48'h0}, 1,
                               '{otat_pkg::STAT_NOT_FOUND, 0}});
    // id wins over class
    plan.insert(plan.size(), '{'{otat_pkg::CMD_POSE, 5, 0, 1, -1, -1, -1, 64'h0, 48'h0}, 1,
                               '{otat_pkg::STAT_POSE_UPDATED, 5}});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_DETECT, 0, 0, 0, 600, 500, 0, 64'h0, 48'h0},
                               0, '0});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_DETECT, 0, 4, 0, 0, 0, 32767, 64'h0, 48'h0},
                               0, '0});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_DETECT, 0, 2, 0, 1000, 1000, 0, 64'h0, 48'h0},
                               0, '0});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_DETECT, 0, 0, 0, -200, -200, 0, 64'h0, 48'h0},
                               0, '0});
    plan.insert(plan.size(), '{'{otat_pkg::CMD_POSE, 6, 9, 0, 123, -456, 0, 64'h0, 48'h0},
                               0, '0});
    foreach (plan[r]) send_word(plan[r].word, plan[r].typed, plan[r].want);

    for (p = 0; p < 5; p++) begin
      case (p)
        0: begin
          gate = otat_pkg::MERGE_DIST_RST;
          mask_word = CFG_DATA_W'(otat_pkg::LIMITED_RST);
          n = 100;
          spread = 400;
        end
        1: begin gate = '0; mask_word = 31'h0000_FFFF; n = 70; spread = 100; end
        2: begin gate = '1; mask_word = '0; n = 70; spread = 30000; end
        // no gate and no limited class: each detection adds while there is room, fills the table
        3: begin gate = '0; mask_word = '0; n = 110; spread = 500; end
        default: begin
          gate = CFG_DATA_W'($urandom_range(0, 4_000_000));
          mask_word = CFG_DATA_W'($urandom);
          n = 100;
          spread = 2000;
        end
      endcase
      calm_stretch = (p == 2);
      program_gate(gate, mask_word);
      for (j = 0; j < n; j++) begin
        if (p == 0 && j == 50) drain_results();
        send_word(random_word(spread), 1'b0, '0);
      end
    end

    drain_results();
    repeat (80) @(posedge clk);
    $display("Sent %0d words under %0d gate/mask settings, %0d results checked, %0d mismatches.",
             words_sent, settings_used, checked, mismatches);
    $display("Outcomes: %0d merged, %0d added, %0d pose updated, %0d not found, %0d table full.",
             status_seen[otat_pkg::STAT_MERGED], status_seen[otat_pkg::STAT_ADDED],
             status_seen[otat_pkg::STAT_POSE_UPDATED], status_seen[otat_pkg::STAT_NOT_FOUND],
             status_seen[otat_pkg::STAT_TABLE_FULL]);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("** object_track_association_table_top: PASSED **");
    end else begin
      $display("** object_track_association_table_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/otat_pkg.sv
hw/rtl/otat_scan_mem.sv
hw/rtl/otat_attr_mem.sv
hw/rtl/otat_ctrl.sv
hw/rtl/object_track_association_table_top.sv
tb/sv/object_track_association_table_top_tb.sv
